// ===== design/cdl_pkg.sv =====
// Package for the circular keyed list: word types, codes and sizes.
// Used by the cell, the cell row and the top level.
`timescale 1ns / 1ps
package cdl_pkg;
    localparam int Capacity = 64;
    localparam int CntW = $clog2(Capacity + 1);

    typedef enum logic [2:0] {
        FN_ADD = 3'd0, FN_REMOVE = 3'd1, FN_SEARCH = 3'd2,
        FN_FWD = 3'd3, FN_REV = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_DUP = 3'd1, ST_NOTFOUND = 3'd2,
        ST_EMPTY = 3'd3, ST_FULL = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]   func;
        logic signed [31:0] code;
        logic [31:0]  desc_handle;
    } t_in_word;

    typedef struct packed {
        logic [2:0]   status;
        logic signed [31:0] entry_code;
        logic [31:0]  entry_desc;
        logic         last;
    } t_out_word;

    typedef struct packed {
        logic [31:0] code;
        logic [31:0] desc;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   del;
        logic   shift;
        t_entry ins_data;
    } t_row_ctl;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_ADD, S_EMIT, S_ONE
    } t_state;
endpackage

// ===== design/circular_doubly_linked_keyed_list_top.sv =====
// Top level of the circular keyed list: sequencer, output register, cell row.
// Depends on cdl_pkg and cdl_row.
`timescale 1ns / 1ps
// channel | valid   | stall   | word
// in      | i_valid | o_stall | i_in  (t_in_word)
// out     | o_valid | i_stall | o_out (t_out_word)
// Add, remove and search: one full rotation in S_SCAN, then the result word in S_ONE, then idle.
// Forward walk: one word per cycle from the head while out is not stalled, then idle.
// Reverse walk: for each word, S_ADD rotates the next word back to the head, then S_EMIT sends it.
// Unused func: accepted and dropped in the accept cycle.
// Reset clears state, count and cell valid bits; out stalls hold only S_EMIT and S_ONE.
module circular_doubly_linked_keyed_list_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  cdl_pkg::t_in_word i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output cdl_pkg::t_out_word o_out
);
    localparam int CW = cdl_pkg::CntW;
    cdl_pkg::t_state r_state, n_state;
    cdl_pkg::t_in_word r_cmd, n_cmd;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx, r_pos, n_pos;
    logic r_hit, n_hit;
    cdl_pkg::t_entry r_hit_e, n_hit_e;
    cdl_pkg::t_out_word r_out, n_out;
    logic r_ov, n_ov;
    cdl_pkg::t_row_ctl w_ctl;
    cdl_pkg::t_entry w_head;
    logic [CW-1:0] w_delpos;

    cdl_row u_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_count(r_cnt), .i_del_pos(w_delpos), .o_head(w_head)
    );

    // scan reads entry r_idx at the head by rotating: head moves to tail each step
    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_cnt = r_cnt; n_idx = r_idx;
        n_pos = r_pos; n_hit = r_hit; n_hit_e = r_hit_e;
        n_out = r_out; n_ov = r_ov;
        w_ctl = '0; w_delpos = {CW{1'b1}};
        if (r_ov && !i_stall) n_ov = 1'b0;
        o_stall = (r_state != cdl_pkg::S_IDLE);
        case (r_state)
            cdl_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_in; n_idx = '0; n_hit = 1'b0;
                    if (i_in.func == cdl_pkg::FN_FWD || i_in.func == cdl_pkg::FN_REV) begin
                        if (r_cnt == '0) n_state = cdl_pkg::S_ONE;
                        else if (i_in.func == cdl_pkg::FN_FWD) n_state = cdl_pkg::S_EMIT;
                        else begin
                            n_state = cdl_pkg::S_ADD; n_pos = '0;
                        end
                    end else if (i_in.func <= cdl_pkg::FN_SEARCH)
                        n_state = cdl_pkg::S_SCAN;
                end
            end
            cdl_pkg::S_SCAN: begin
                // rotate the whole row once, noting the match position
                if (r_idx == r_cnt) begin
                    n_state = cdl_pkg::S_ONE;
                end else begin
                    if (w_head.code == r_cmd.code && !r_hit) begin
                        n_hit = 1'b1; n_hit_e = w_head; n_pos = r_idx;
                    end
                    w_ctl.shift = 1'b1; w_ctl.ins = 1'b1; w_ctl.ins_data = w_head;
                    n_idx = r_idx + 1'b1;
                end
            end
            cdl_pkg::S_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_out.status = cdl_pkg::ST_OK;
                    n_out.last = (r_idx == r_cnt - 1'b1);
                    n_out.entry_code = w_head.code; n_out.entry_desc = w_head.desc;
                    if (r_cmd.func == cdl_pkg::FN_FWD) begin
                        w_ctl.shift = 1'b1; w_ctl.ins = 1'b1; w_ctl.ins_data = w_head;
                    end
                    n_idx = r_idx + 1'b1;
                    if (r_idx == r_cnt - 1'b1) begin
                        n_state = cdl_pkg::S_IDLE;
                        n_idx = '0;
                    end else if (r_cmd.func == cdl_pkg::FN_REV) begin
                        n_state = cdl_pkg::S_ADD; n_pos = '0;
                    end
                end
            end
            cdl_pkg::S_ADD: begin
                // reverse walk: rotate until the word before the last one sent (first the tail) is at the head
                if (r_pos == r_cnt - 1'b1) begin
                    n_state = cdl_pkg::S_EMIT;
                end else begin
                    w_ctl.shift = 1'b1; w_ctl.ins = 1'b1; w_ctl.ins_data = w_head;
                    n_pos = r_pos + 1'b1;
                end
            end
            cdl_pkg::S_ONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1; n_out = '0; n_out.last = 1'b1;
                    n_state = cdl_pkg::S_IDLE;
                    case (r_cmd.func)
                        cdl_pkg::FN_ADD: begin
                            if (r_hit) n_out.status = cdl_pkg::ST_DUP;
                            else if (r_cnt == CW'(cdl_pkg::Capacity))
                                n_out.status = cdl_pkg::ST_FULL;
                            else begin
                                n_out.status = cdl_pkg::ST_OK;
                                n_out.entry_code = r_cmd.code;
                                n_out.entry_desc = r_cmd.desc_handle;
                                w_ctl.ins = 1'b1;
                                w_ctl.ins_data = {r_cmd.code, r_cmd.desc_handle};
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        cdl_pkg::FN_REMOVE, cdl_pkg::FN_SEARCH: begin
                            if (!r_hit) n_out.status = cdl_pkg::ST_NOTFOUND;
                            else begin
                                n_out.status = cdl_pkg::ST_OK;
                                n_out.entry_code = r_hit_e.code;
                                n_out.entry_desc = r_hit_e.desc;
                                if (r_cmd.func == cdl_pkg::FN_REMOVE) begin
                                    w_ctl.del = 1'b1; w_delpos = r_pos;
                                    n_cnt = r_cnt - 1'b1;
                                end
                            end
                        end
                        default: n_out.status = cdl_pkg::ST_EMPTY;
                    endcase
                end
            end
            default: n_state = cdl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_idx <= n_idx; r_pos <= n_pos; r_hit_e <= n_hit_e;
        r_out <= n_out; r_hit <= n_hit;
        if (!i_rst_n) begin
            r_state <= cdl_pkg::S_IDLE; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_ov <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_out = r_out;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(cdl_pkg::Capacity)) else $error("count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != cdl_pkg::S_IDLE |-> o_stall) else $error("accept while busy");
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cdl_pkg::S_SCAN |=> $stable(r_cnt)) else $error("count moved in scan");
endmodule

// ===== design/cdl_cell.sv =====
// One list position: holds an entry and its valid bit, shifts toward the head.
// Depends on cdl_pkg.
`timescale 1ns / 1ps
module cdl_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cdl_pkg::t_row_ctl i_ctl,
    input  logic           i_is_tail,
    input  logic           i_del_here,
    input  logic           i_del_below,
    input  cdl_pkg::t_entry i_from_next,
    input  logic           i_valid_next,
    output cdl_pkg::t_entry o_entry,
    output logic           o_valid
);
    cdl_pkg::t_entry r_entry, n_entry;
    logic r_valid, n_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.ins && i_is_tail) begin
            n_entry = i_ctl.ins_data;
            n_valid = 1'b1;
        end else if (i_ctl.del && (i_del_here || i_del_below)) begin
            n_entry = i_from_next;
            n_valid = i_valid_next;
        end else if (i_ctl.shift) begin
            n_entry = i_from_next;
            n_valid = i_valid_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= n_valid;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
endmodule

// ===== design/cdl_row.sv =====
// Row of list cells in list order; position 0 is the head.
// Depends on cdl_pkg and cdl_cell.
`timescale 1ns / 1ps
module cdl_row (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdl_pkg::t_row_ctl i_ctl,
    input  logic [cdl_pkg::CntW-1:0] i_count,
    input  logic [cdl_pkg::CntW-1:0] i_del_pos,
    output cdl_pkg::t_entry   o_head
);
    localparam int N = cdl_pkg::Capacity;
    cdl_pkg::t_entry w_e [N+1];
    logic w_v [N+1];
    logic [cdl_pkg::CntW-1:0] w_ins_pos;

    assign w_e[N] = '0;
    assign w_v[N] = 1'b0;

    // on a rotation the head lands in the last occupied cell
    assign w_ins_pos = i_ctl.shift ? i_count - 1'b1 : i_count;

    for (genvar g = 0; g < N; g++) begin : g_cell
        cdl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_is_tail  (w_ins_pos == cdl_pkg::CntW'(g)),
            .i_del_here (i_del_pos == cdl_pkg::CntW'(g)),
            .i_del_below(i_del_pos < cdl_pkg::CntW'(g)),
            .i_from_next(w_e[g+1]),
            .i_valid_next(w_v[g+1]),
            .o_entry    (w_e[g]),
            .o_valid    (w_v[g])
        );
    end

    assign o_head = w_e[0];
endmodule

// ===== bench/circular_doubly_linked_keyed_list_top_tb.sv =====
// Testbench for the circular keyed list: predicts every result word from its own
// list model and checks the output channel. Depends on cdl_pkg and the top level.
`timescale 1ns / 1ps
module circular_doubly_linked_keyed_list_top_tb;
    localparam int WatchLimit = 20000;
    localparam int HoldCycles = 400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    cdl_pkg::t_in_word  i_in = '0;
    logic      o_stall;
    logic      o_valid;
    cdl_pkg::t_out_word o_out;

    circular_doubly_linked_keyed_list_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_in(i_in), .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out)
    );

    always #1 i_clk = ~i_clk;

    // list model: entries kept in list order, head first
    logic [31:0] list_codes[$];
    logic [31:0] list_descs[$];
    cdl_pkg::t_out_word expected_words[$];
    cdl_pkg::t_in_word  pending_words[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  hold_off = 0;
    bit  hold_done = 0;
    int  hold_cnt = 0;
    int  gap_left = 0;
    int  burst_left = 0;

    function automatic cdl_pkg::t_out_word make_word(cdl_pkg::t_status st, logic [31:0] c,
                                                     logic [31:0] d, logic l);
        cdl_pkg::t_out_word w;
        w.status = st;
        w.entry_code = c;
        w.entry_desc = d;
        w.last = l;
        return w;
    endfunction

    function automatic int find_code(logic [31:0] c);
        foreach (list_codes[k]) if (list_codes[k] == c) return k;
        return -1;
    endfunction

    task automatic predict_list(cdl_pkg::t_in_word w);
        int k;
        int n;
        n = list_codes.size();
        k = find_code(w.code);
        case (w.func)
            cdl_pkg::FN_ADD: begin
                if (k >= 0) expected_words.push_back(make_word(cdl_pkg::ST_DUP, 0, 0, 1));
                else if (n >= cdl_pkg::Capacity)
                    expected_words.push_back(make_word(cdl_pkg::ST_FULL, 0, 0, 1));
                else begin
                    list_codes.push_back(w.code);
                    list_descs.push_back(w.desc_handle);
                    expected_words.push_back(make_word(cdl_pkg::ST_OK, w.code,
                                                       w.desc_handle, 1));
                end
            end
            cdl_pkg::FN_REMOVE, cdl_pkg::FN_SEARCH: begin
                if (k < 0)
                    expected_words.push_back(make_word(cdl_pkg::ST_NOTFOUND, 0, 0, 1));
                else begin
                    expected_words.push_back(make_word(cdl_pkg::ST_OK, list_codes[k],
                                                       list_descs[k], 1));
                    if (w.func == cdl_pkg::FN_REMOVE) begin
                        list_codes.delete(k);
                        list_descs.delete(k);
                    end
                end
            end
            cdl_pkg::FN_FWD, cdl_pkg::FN_REV: begin
                if (n == 0) expected_words.push_back(make_word(cdl_pkg::ST_EMPTY, 0, 0, 1));
                else for (int i = 0; i < n; i++) begin
                    k = (w.func == cdl_pkg::FN_FWD) ? i : n - 1 - i;
                    expected_words.push_back(make_word(cdl_pkg::ST_OK, list_codes[k],
                                                       list_descs[k], i == n - 1));
                end
            end
            default: ;
        endcase
    endtask

    function automatic cdl_pkg::t_in_word make_in(cdl_pkg::t_func f, logic [31:0] c,
                                                  logic [31:0] d);
        cdl_pkg::t_in_word w;
        w.func = f;
        w.code = c;
        w.desc_handle = d;
        return w;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_list(i_in);
                void'(pending_words.pop_front());
            end
            if (i_valid && o_stall) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(20, 1);
                    gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(6);
                    i_valid <= 1'b0;
                end else begin
                    burst_left <= burst_left - 1;
                    i_valid <= 1'b1;
                    i_in <= pending_words[0];
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (hold_off && !hold_done) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= HoldCycles) hold_done <= 1'b1;
        end else begin
            if ($urandom_range(60) == 0) stall_mode <= $urandom_range(2);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= $urandom_range(3) == 0;
                default: i_stall <= $urandom_range(1);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cdl_pkg::t_out_word e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", o_out);
                end else begin
                    e = expected_words.pop_front();
                    if (o_out.status !== e.status || o_out.entry_code !== e.entry_code ||
                        o_out.entry_desc !== e.entry_desc || o_out.last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: expected %p actual %p", e, o_out);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) timed_out <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_code(bit known);
        if (known && list_codes.size() > 0 && $urandom_range(3) != 0)
            return list_codes[$urandom_range(list_codes.size() - 1)];
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return $urandom;
            2: return 32'h8000_0000 + $urandom_range(3);
            default: return 32'hFFFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    task automatic wait_drained();
        while ((pending_words.size() > 0 || expected_words.size() > 0) && !timed_out)
            @(posedge i_clk);
    endtask

    initial begin
        int f;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        pending_words.push_back(make_in(cdl_pkg::FN_FWD, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_REV, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_SEARCH, 5, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_REMOVE, 5, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'h8000_0000, 32'h0));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 0, 32'hA5A5_5A5A));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'hFFFF_FFFF, 32'h5A5A_A5A5));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 0, 32'h1));
        pending_words.push_back(make_in(cdl_pkg::FN_FWD, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_REV, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_SEARCH, 32'h8000_0000, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_REMOVE, 32'h7FFF_FFFF, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_FWD, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'h1234, 32'h77));
        pending_words.push_back(make_in(cdl_pkg::t_func'(3'd5), 0, 0));
        pending_words.push_back(make_in(cdl_pkg::t_func'(3'd7), 1, 1));
        pending_words.push_back(make_in(cdl_pkg::FN_REMOVE, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_REV, 0, 0));
        wait_drained();

        // fill to capacity, then overflow, while the receiver holds off
        hold_off = 1;
        for (int i = 0; i < cdl_pkg::Capacity; i++)
            pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'h100 + i, $urandom));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'h5555, 1));
        pending_words.push_back(make_in(cdl_pkg::FN_ADD, 32'h100, 1));
        wait (hold_done || timed_out);
        hold_off = 0;
        pending_words.push_back(make_in(cdl_pkg::FN_FWD, 0, 0));
        pending_words.push_back(make_in(cdl_pkg::FN_REV, 0, 0));
        wait_drained();
        for (int i = 0; i < cdl_pkg::Capacity; i += 2)
            pending_words.push_back(make_in(cdl_pkg::FN_REMOVE, 32'h100 + i, 0));
        wait_drained();

        // random
        for (int i = 0; i < 80; i++) begin
            wait (pending_words.size() < 4 || timed_out);
            f = $urandom_range(99);
            if (f < 40)
                pending_words.push_back(make_in(cdl_pkg::FN_ADD,
                                                pick_code($urandom_range(4) == 0),
                                                $urandom));
            else if (f < 65)
                pending_words.push_back(make_in(cdl_pkg::FN_REMOVE, pick_code(1), 0));
            else if (f < 85)
                pending_words.push_back(make_in(cdl_pkg::FN_SEARCH, pick_code(1), $urandom));
            else if (f < 93)
                pending_words.push_back(make_in(cdl_pkg::FN_FWD, $urandom, $urandom));
            else if (f < 98)
                pending_words.push_back(make_in(cdl_pkg::FN_REV, $urandom, $urandom));
            else pending_words.push_back(make_in(cdl_pkg::t_func'($urandom_range(7, 5)),
                                                 $urandom, $urandom));
            @(posedge i_clk);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (!timed_out && mismatches == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("Verification failed");
            $finish;
        end
    end
endmodule
